/* sv/ssvg_pkg.sv */
// Shared constants and types for the strip speckle variance block.
package ssvg_pkg;

  // Parameter defaults
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_STRIP_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register and field widths
  localparam int COLS_W     = 11;
  localparam int ROWS_W     = 13;
  localparam int STRIP_W    = 7;
  localparam int OFF_W      = 12;
  localparam int LVL_W      = 16;
  localparam int VAR_W      = 31;
  localparam int COLF_W     = 10;
  localparam int STRF_W     = 12;
  localparam int OUT_TW     = 56;
  localparam int BASE_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // Register reset values
  localparam logic [COLS_W-1:0]  COLS_RST  = 11'd1024;
  localparam logic [ROWS_W-1:0]  ROWS_RST  = 13'd1024;
  localparam logic [STRIP_W-1:0] STRIP_RST = 7'd8;
  localparam logic [OFF_W-1:0]   OFF_RST   = 12'd0;
  localparam logic [LVL_W-1:0]   MIN_RST   = 16'd0;
  localparam logic [LVL_W-1:0]   MAX_RST   = 16'hFFFF;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS    = 3'd0,
    REG_ROWS       = 3'd1,
    REG_STRIP_SIZE = 3'd2,
    REG_ROW_OFFSET = 3'd3,
    REG_MIN_LEVEL  = 3'd4,
    REG_MAX_LEVEL  = 3'd5
  } cfg_reg_t;

endpackage

/* sv/ssvg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ssvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ssvg_div.sv */
// Restoring divider, one quotient bit per cycle.
module ssvg_div #(
  parameter int NW = 45,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, q_r[NW-1]};
    trial    = shifted - {1'b0, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

/* sv/strip_speckle_variance_gated_core.sv */
// Top level: per-column strip accumulation in RAM and gated variance output.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tdata: sample
//  out_    | out | tvalid/tready       | out_tdata: variance, column, strip; tlast
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample outside a strip is taken in S_IDLE; a strip sample also passes S_MOD
// (RAM read, then modify and write back). On a strip's last row the variance
// passes S_MUL1, S_MUL2 (multiply) and S_DSTART, then the shared bit-serial divider.
// Reset is synchronous; RAM contents are not cleared, the first row of each
// strip overwrites them. A stalled out_ beat holds the next result in the divider.
module strip_speckle_variance_gated_core #(
  parameter int MAX_COLUMNS = ssvg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_STRIP   = ssvg_pkg::MAX_STRIP_DEF,
  parameter int SAMPLE_BITS = ssvg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [ssvg_pkg::OUT_TW-1:0]            out_tdata,  // variance, column, strip
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ssvg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssvg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int NB   = $clog2(MAX_STRIP + 1);
  localparam int SRW  = $clog2(MAX_STRIP);
  localparam int SUMW = SAMPLE_BITS + $clog2(MAX_STRIP);
  localparam int SQW  = 2 * SAMPLE_BITS + $clog2(MAX_STRIP);
  localparam int NW   = SQW + NB;
  localparam int DW   = 2 * NB;
  localparam int GW   = SUMW + ssvg_pkg::LVL_W;
  localparam int BW   = ssvg_pkg::BASE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_MUL1, S_MUL2, S_DSTART, S_DIV
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ssvg_pkg::COLS_W-1:0]  columns_r, columns_nxt;
  logic [ssvg_pkg::ROWS_W-1:0]  rows_r, rows_nxt;
  logic [ssvg_pkg::STRIP_W-1:0] strip_size_r, strip_size_nxt;
  logic [ssvg_pkg::OFF_W-1:0]   row_offset_r, row_offset_nxt;
  logic [ssvg_pkg::LVL_W-1:0]   min_level_r, min_level_nxt;
  logic [ssvg_pkg::LVL_W-1:0]   max_level_r, max_level_nxt;

  // frame position
  logic [CW-1:0]                col_r, col_nxt;
  logic [ssvg_pkg::ROWS_W-1:0]  row_r, row_nxt;
  logic [SRW-1:0]               srow_r, srow_nxt;
  logic [ssvg_pkg::STRF_W-1:0]  strip_r, strip_nxt;
  logic [BW-1:0]                base_r, base_nxt;   // first row of current strip

  // item in flight
  logic [CW-1:0]                it_addr_r, it_addr_nxt;
  logic [ssvg_pkg::STRF_W-1:0]  it_strip_r, it_strip_nxt;
  logic                         it_lastf_r, it_lastf_nxt;
  logic                         it_first_r, it_first_nxt;
  logic                         it_lastrow_r, it_lastrow_nxt;
  logic [SAMPLE_BITS-1:0]       s_r, s_nxt;
  logic [2*SAMPLE_BITS-1:0]     ssq_r, ssq_nxt;

  // arithmetic
  logic [SUMW-1:0]              sum_r, sum_nxt;
  logic [SQW-1:0]               sq_r, sq_nxt;
  logic [2*SUMW-1:0]            sumsq_r, sumsq_nxt;
  logic [NW-1:0]                nsq_r, nsq_nxt;
  logic                         gate_r, gate_nxt;

  // output
  logic                         out_valid_r, out_valid_nxt;
  logic [ssvg_pkg::VAR_W-1:0]   out_var_r, out_var_nxt;
  logic [ssvg_pkg::COLF_W-1:0]  out_col_r, out_col_nxt;
  logic [ssvg_pkg::STRF_W-1:0]  out_strip_r, out_strip_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         cfg_we;
  logic                         restart;
  logic                         in_acc;
  logic [CW:0]                  cols_eff;
  logic [ssvg_pkg::ROWS_W-1:0]  rows_eff;
  logic                         n_ok;
  logic [NB-1:0]                n_w;
  logic [BW-1:0]                n_b;
  logic                         frame_ok;
  logic                         in_strip;
  logic                         col_wrap;
  logic                         srow_last;

  logic                         ram_re;
  logic                         ram_we;
  logic [SUMW+SQW-1:0]          ram_rdata;
  logic [SUMW+SQW-1:0]          ram_wdata;

  logic                         div_start;
  logic                         div_busy;
  logic [NW-1:0]                div_q;
  logic [NW-1:0]                div_num;
  logic [DW-1:0]                div_den;
  logic [GW-1:0]                lo_lvl;
  logic [GW-1:0]                hi_lvl;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_we    = cfg_valid && (cfg_index <= ssvg_pkg::REG_MAX_LEVEL);

  always_comb begin
    if (columns_r == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      cols_eff = (CW+1)'(MAX_COLUMNS);
    end else begin
      cols_eff = (CW+1)'(columns_r);
    end
  end

  assign rows_eff  = (rows_r == '0) ? ssvg_pkg::ROWS_W'(1) : rows_r;
  assign n_ok      = (strip_size_r >= ssvg_pkg::STRIP_W'(2)) &&
                     (32'(strip_size_r) <= MAX_STRIP);
  assign n_w       = NB'(strip_size_r);
  assign n_b       = BW'(strip_size_r);
  // at least two whole strips after the offset
  assign frame_ok  = n_ok && (BW'(row_offset_r) + n_b + n_b <= BW'(rows_eff));
  assign in_strip  = frame_ok && (row_r >= ssvg_pkg::ROWS_W'(row_offset_r)) &&
                     (base_r + n_b <= BW'(rows_eff));
  assign col_wrap  = ((CW+1)'(col_r) + (CW+1)'(1)) == cols_eff;
  assign srow_last = (32'(srow_r) + 32'd1) == 32'(strip_size_r);

  assign lo_lvl    = GW'(n_w) * GW'(min_level_r);
  assign hi_lvl    = GW'(n_w) * GW'(max_level_r);
  assign div_num   = nsq_r - NW'(sumsq_r);
  assign div_den   = DW'(n_w) * DW'(n_w - NB'(1));
  assign div_start = (state_r == S_DSTART);

  assign ram_re    = in_acc && in_strip;
  assign ram_we    = (state_r == S_MOD);
  assign ram_wdata = {sq_nxt, sum_nxt};

  always_comb begin
    state_nxt      = state_r;
    columns_nxt    = columns_r;
    rows_nxt       = rows_r;
    strip_size_nxt = strip_size_r;
    row_offset_nxt = row_offset_r;
    min_level_nxt  = min_level_r;
    max_level_nxt  = max_level_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    srow_nxt       = srow_r;
    strip_nxt      = strip_r;
    base_nxt       = base_r;
    it_addr_nxt    = it_addr_r;
    it_strip_nxt   = it_strip_r;
    it_lastf_nxt   = it_lastf_r;
    it_first_nxt   = it_first_r;
    it_lastrow_nxt = it_lastrow_r;
    s_nxt          = s_r;
    ssq_nxt        = ssq_r;
    sum_nxt        = sum_r;
    sq_nxt         = sq_r;
    sumsq_nxt      = sumsq_r;
    nsq_nxt        = nsq_r;
    gate_nxt       = gate_r;
    out_valid_nxt  = out_valid_r;
    out_var_nxt    = out_var_r;
    out_col_nxt    = out_col_r;
    out_strip_nxt  = out_strip_r;
    out_last_nxt   = out_last_r;
    restart        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      restart = 1'b1;
      case (cfg_index)
        ssvg_pkg::REG_COLUMNS:    columns_nxt    = cfg_data[ssvg_pkg::COLS_W-1:0];
        ssvg_pkg::REG_ROWS:       rows_nxt       = cfg_data[ssvg_pkg::ROWS_W-1:0];
        ssvg_pkg::REG_STRIP_SIZE: strip_size_nxt = cfg_data[ssvg_pkg::STRIP_W-1:0];
        ssvg_pkg::REG_ROW_OFFSET: row_offset_nxt = cfg_data[ssvg_pkg::OFF_W-1:0];
        ssvg_pkg::REG_MIN_LEVEL:  min_level_nxt  = cfg_data;
        ssvg_pkg::REG_MAX_LEVEL:  max_level_nxt  = cfg_data;
        default:                  restart        = 1'b0;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          s_nxt          = in_tdata[SAMPLE_BITS-1:0];
          ssq_nxt        = (2*SAMPLE_BITS)'(in_tdata[SAMPLE_BITS-1:0]) *
                           (2*SAMPLE_BITS)'(in_tdata[SAMPLE_BITS-1:0]);
          it_addr_nxt    = col_r;
          it_strip_nxt   = strip_r;
          it_first_nxt   = (srow_r == '0);
          it_lastrow_nxt = srow_last;
          it_lastf_nxt   = col_wrap && (base_r + n_b + n_b > BW'(rows_eff));
          if (in_strip) begin
            state_nxt = S_MOD;
          end
          // advance frame position
          if (col_wrap) begin
            col_nxt = '0;
            if (in_strip) begin
              if (srow_last) begin
                srow_nxt  = '0;
                strip_nxt = strip_r + 1'b1;
                base_nxt  = base_r + n_b;
              end else begin
                srow_nxt = srow_r + 1'b1;
              end
            end
            if (row_r + 1'b1 >= rows_eff) begin
              row_nxt   = '0;
              srow_nxt  = '0;
              strip_nxt = '0;
              base_nxt  = BW'(row_offset_r);
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      S_MOD: begin
        if (it_first_r) begin
          sum_nxt = SUMW'(s_r);
          sq_nxt  = SQW'(ssq_r);
        end else begin
          sum_nxt = ram_rdata[SUMW-1:0] + SUMW'(s_r);
          sq_nxt  = ram_rdata[SUMW+SQW-1:SUMW] + SQW'(ssq_r);
        end
        state_nxt = it_lastrow_r ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        sumsq_nxt = (2*SUMW)'(sum_r) * (2*SUMW)'(sum_r);
        gate_nxt  = (GW'(sum_r) >= lo_lvl) && (GW'(sum_r) <= hi_lvl);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        nsq_nxt   = NW'(n_w) * NW'(sq_r);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_busy && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          if (!gate_r) begin
            out_var_nxt = '0;
          end else if (div_q > NW'(ssvg_pkg::VAR_MAX)) begin
            out_var_nxt = ssvg_pkg::VAR_MAX;
          end else begin
            out_var_nxt = div_q[ssvg_pkg::VAR_W-1:0];
          end
          out_col_nxt   = ssvg_pkg::COLF_W'(it_addr_r);
          out_strip_nxt = it_strip_r;
          out_last_nxt  = it_lastf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      srow_nxt  = '0;
      strip_nxt = '0;
      base_nxt  = BW'(row_offset_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      columns_r    <= ssvg_pkg::COLS_RST;
      rows_r       <= ssvg_pkg::ROWS_RST;
      strip_size_r <= ssvg_pkg::STRIP_RST;
      row_offset_r <= ssvg_pkg::OFF_RST;
      min_level_r  <= ssvg_pkg::MIN_RST;
      max_level_r  <= ssvg_pkg::MAX_RST;
      col_r        <= '0;
      row_r        <= '0;
      srow_r       <= '0;
      strip_r      <= '0;
      base_r       <= BW'(ssvg_pkg::OFF_RST);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      columns_r    <= columns_nxt;
      rows_r       <= rows_nxt;
      strip_size_r <= strip_size_nxt;
      row_offset_r <= row_offset_nxt;
      min_level_r  <= min_level_nxt;
      max_level_r  <= max_level_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      srow_r       <= srow_nxt;
      strip_r      <= strip_nxt;
      base_r       <= base_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    it_addr_r    <= it_addr_nxt;
    it_strip_r   <= it_strip_nxt;
    it_lastf_r   <= it_lastf_nxt;
    it_first_r   <= it_first_nxt;
    it_lastrow_r <= it_lastrow_nxt;
    s_r          <= s_nxt;
    ssq_r        <= ssq_nxt;
    sum_r        <= sum_nxt;
    sq_r         <= sq_nxt;
    sumsq_r      <= sumsq_nxt;
    nsq_r        <= nsq_nxt;
    gate_r       <= gate_nxt;
    out_var_r    <= out_var_nxt;
    out_col_r    <= out_col_nxt;
    out_strip_r  <= out_strip_nxt;
    out_last_r   <= out_last_nxt;
  end

  ssvg_ram #(
    .WIDTH (SUMW + SQW),
    .DEPTH (MAX_COLUMNS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  ssvg_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_strip_r, out_col_r, out_var_r};

endmodule
